>>> rtl/core/trdq_pkg.sv
package trdq_pkg;

	// queue geometry
	localparam int QUEUE_DEPTH = 64;
	localparam int IDX_W       = $clog2(QUEUE_DEPTH);
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// statistics format
	localparam int FRAC_BITS   = 4;
	localparam int ALPHA_SHIFT = 4;
	localparam int ACC_W       = 20;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;
	localparam logic [31:0] TQ_LIMIT = 32'(ACC_MAX >> FRAC_BITS);

	localparam int TAG_W  = 16;
	localparam int TIME_W = 32;
	localparam int DLY_W  = 16;
	localparam int XFER_W = 16;
	localparam logic [31:0] XFER_MAX = 32'((1 << XFER_W) - 1);

	typedef enum logic [1:0] {
		STAT_NONE = 2'd0,
		STAT_REL  = 2'd1,
		STAT_ENQ  = 2'd2,
		STAT_DROP = 2'd3
	} status_t;

	typedef enum logic {
		OP_TICK = 1'b0,
		OP_ENQ  = 1'b1
	} opcode_t;

	typedef struct packed {
		logic [TAG_W-1:0]  tag;
		logic [TIME_W-1:0] arrival;
		logic [TIME_W-1:0] release_t;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// shared add/sub unit control and flags
	typedef struct packed {
		logic        sub;
		logic [31:0] a;
		logic [31:0] b;
	} alu_req_t;

	typedef struct packed {
		logic [31:0] y;
		logic        zero;
		logic        neg;
	} alu_rsp_t;

endpackage

>>> rtl/core/trdq_ram.sv
module trdq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/trdq_alu.sv
module trdq_alu
	import trdq_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [31:0] y;

	// one 32-bit adder, b inverted with carry in for subtract
	assign y        = req.a + (req.sub ? ~req.b : req.b) + 32'(req.sub);
	assign rsp.y    = y;
	assign rsp.zero = (y == '0);
	assign rsp.neg  = y[31];

endmodule

>>> rtl/core/timed_release_delay_queue.sv
// timed release delay queue. a word with opcode enqueue stores seq_tag with the
// current millisecond time and a release time of now plus delay_ms, or is dropped
// (status 3) when all 64 entries are taken; status 2 otherwise. a tick word first
// advances the millisecond count, then releases at most one entry: the oldest one
// whose release time has come (wrap-safe signed compare). a release reports the tag,
// the transit time saturated to 65535, and the updated ewma mean and mean absolute
// deviation (alpha 1/16, four fraction bits); mean_transit_q4 and jitter_q4 carry
// the current values with every result. start is taken when busy is low; each word
// gives exactly one result, shown for one cycle with done high, and the receiver
// cannot stall it. enqueue, drop and a tick on an empty queue finish straight from
// idle, done rising in the cycle after the word is taken. any other tick walks the
// queue one entry per cycle through the single read port of the entry memory: a
// release scans up to the due entry, copies down the entries behind it, then takes
// seven steps on the one shared 32-bit adder for transit and statistics before done
// rises. a tick with nothing due scans every stored entry, then raises done. the
// entry memory needs no clearing after reset, so the block is ready right out of
// reset.
module timed_release_delay_queue
	import trdq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                opcode,
	input  logic [TAG_W-1:0]    seq_tag,
	input  logic [DLY_W-1:0]    delay_ms,
	output logic                done,
	output logic [1:0]          status,
	output logic [TAG_W-1:0]    released_tag,
	output logic [XFER_W-1:0]   transit_ms,
	output logic [ACC_W-1:0]    mean_transit_q4,
	output logic [ACC_W-1:0]    jitter_q4
);

	// sequencer: scan, copy down, then the statistics steps on the adder
	typedef enum logic [9:0] {
		S_IDLE  = 10'b00_0000_0001,
		S_SCAN  = 10'b00_0000_0010,
		S_SHIFT = 10'b00_0000_0100,
		S_T     = 10'b00_0000_1000,
		S_M1    = 10'b00_0001_0000,
		S_M2    = 10'b00_0010_0000,
		S_D     = 10'b00_0100_0000,
		S_DN    = 10'b00_1000_0000,
		S_V1    = 10'b01_0000_0000,
		S_V2    = 10'b10_0000_0000
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  idx_q;
	logic [TIME_W-1:0] now_q;
	logic [ACC_W-1:0]  mean_q;
	logic [ACC_W-1:0]  dev_q;
	logic [TAG_W-1:0]  tag_q;
	logic [TIME_W-1:0] arrival_q;
	logic [31:0]       t_q;
	logic [31:0]       tmp_q;
	logic [ACC_W-1:0]  d_q;

	// result registers
	logic              done_q;
	status_t           status_q;
	logic [TAG_W-1:0]  rtag_q;
	logic [XFER_W-1:0] rxfer_q;

	logic              accept;
	logic              ram_we;
	logic [IDX_W-1:0]  ram_waddr;
	entry_t            ram_wdata;
	logic [IDX_W-1:0]  ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd_entry;
	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [ACC_W-1:0]  tq;
	logic              is_last;
	logic              more_to_copy;

	assign accept   = start && !busy;
	assign busy     = (state_q != S_IDLE);
	assign rd_entry = entry_t'(ram_rdata);

	// transit in q.4, saturated to the accumulator range
	assign tq = (t_q > TQ_LIMIT) ? ACC_MAX : ACC_W'(t_q << FRAC_BITS);

	assign is_last      = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign more_to_copy = ((CNT_W'(idx_q) + CNT_W'(1)) < cnt_q);

	trdq_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (QUEUE_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	trdq_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// adder operands and memory ports per state
	always_comb begin
		alu_req   = '0;
		ram_we    = 1'b0;
		ram_waddr = cnt_q[IDX_W-1:0];
		ram_wdata = '0;
		ram_raddr = '0;
		unique case (state_q)
			S_IDLE: begin
				// now + 1 for a tick, now + delay for the release stamp
				alu_req.a = now_q;
				alu_req.b = (opcode_t'(opcode) == OP_ENQ) ? 32'(delay_ms) : 32'd1;
				ram_wdata.tag       = seq_tag;
				ram_wdata.arrival   = now_q;
				ram_wdata.release_t = alu_rsp.y;
				ram_we = accept && (opcode_t'(opcode) == OP_ENQ) &&
					(cnt_q != CNT_W'(QUEUE_DEPTH));
			end
			S_SCAN: begin
				// due when release - now is zero or negative
				alu_req.sub = 1'b1;
				alu_req.a   = rd_entry.release_t;
				alu_req.b   = now_q;
				ram_raddr   = idx_q + IDX_W'(1);
			end
			S_SHIFT: begin
				ram_we    = more_to_copy;
				ram_waddr = idx_q;
				ram_wdata = rd_entry;
				ram_raddr = idx_q + IDX_W'(2);
			end
			S_T: begin
				alu_req.sub = 1'b1;
				alu_req.a   = now_q;
				alu_req.b   = arrival_q;
			end
			S_M1: begin
				alu_req.sub = 1'b1;
				alu_req.a   = 32'(mean_q);
				alu_req.b   = 32'(mean_q >> ALPHA_SHIFT);
			end
			S_M2: begin
				alu_req.a = tmp_q;
				alu_req.b = 32'(tq >> ALPHA_SHIFT);
			end
			S_D: begin
				alu_req.sub = 1'b1;
				alu_req.a   = 32'(tq);
				alu_req.b   = 32'(mean_q);
			end
			S_DN: begin
				alu_req.sub = 1'b1;
				alu_req.a   = 32'(mean_q);
				alu_req.b   = 32'(tq);
			end
			S_V1: begin
				alu_req.sub = 1'b1;
				alu_req.a   = 32'(dev_q);
				alu_req.b   = 32'(dev_q >> ALPHA_SHIFT);
			end
			S_V2: begin
				alu_req.a = tmp_q;
				alu_req.b = 32'(d_q >> ALPHA_SHIFT);
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			now_q    <= '0;
			mean_q   <= '0;
			dev_q    <= '0;
			done_q   <= 1'b0;
			status_q <= STAT_NONE;
			rtag_q   <= '0;
			rxfer_q  <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rtag_q  <= '0;
						rxfer_q <= '0;
						if (opcode_t'(opcode) == OP_ENQ) begin
							done_q <= 1'b1;
							if (cnt_q == CNT_W'(QUEUE_DEPTH)) begin
								status_q <= STAT_DROP;
							end else begin
								status_q <= STAT_ENQ;
								cnt_q    <= cnt_q + CNT_W'(1);
							end
						end else begin
							now_q <= alu_rsp.y;
							if (cnt_q == '0) begin
								done_q   <= 1'b1;
								status_q <= STAT_NONE;
							end else begin
								state_q <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					if (alu_rsp.zero || alu_rsp.neg) begin
						tag_q     <= rd_entry.tag;
						arrival_q <= rd_entry.arrival;
						state_q   <= S_SHIFT;
					end else if (is_last) begin
						done_q   <= 1'b1;
						status_q <= STAT_NONE;
						state_q  <= S_IDLE;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_SHIFT: begin
					if (more_to_copy) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						cnt_q   <= cnt_q - CNT_W'(1);
						state_q <= S_T;
					end
				end
				S_T: begin
					t_q     <= alu_rsp.y;
					state_q <= S_M1;
				end
				S_M1: begin
					tmp_q   <= alu_rsp.y;
					state_q <= S_M2;
				end
				S_M2: begin
					mean_q  <= alu_rsp.y[ACC_W-1:0];
					state_q <= S_D;
				end
				S_D: begin
					tmp_q   <= alu_rsp.y;
					state_q <= S_DN;
				end
				S_DN: begin
					// pick the nonnegative of the two differences
					d_q     <= tmp_q[31] ? alu_rsp.y[ACC_W-1:0] : tmp_q[ACC_W-1:0];
					state_q <= S_V1;
				end
				S_V1: begin
					tmp_q   <= alu_rsp.y;
					state_q <= S_V2;
				end
				S_V2: begin
					dev_q    <= alu_rsp.y[ACC_W-1:0];
					done_q   <= 1'b1;
					status_q <= STAT_REL;
					rtag_q   <= tag_q;
					rxfer_q  <= (t_q > XFER_MAX) ? XFER_W'(XFER_MAX) : t_q[XFER_W-1:0];
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (state_q == S_IDLE && accept) begin
				idx_q <= '0;
			end
		end
	end

	assign done            = done_q;
	assign status          = status_q;
	assign released_tag    = rtag_q;
	assign transit_ms      = rxfer_q;
	assign mean_transit_q4 = mean_q;
	assign jitter_q4       = dev_q;

`ifndef SYNTH
	// fill count never passes the queue depth
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above depth");

	// the sequencer holds exactly one state
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// a result word always comes out with the block back at idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> state_q == S_IDLE)
		else $error("result strobe while sequencer busy");

	// an enqueue with room grows the queue by one
	a_enq_count: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode && cnt_q != CNT_W'(QUEUE_DEPTH)) |=>
		(cnt_q == $past(cnt_q) + CNT_W'(1)) && done_q && status_q == STAT_ENQ)
		else $error("enqueue did not grow queue");

	// a release ends with one fewer entry than when the tick began
	a_rel_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT && !more_to_copy) |=> cnt_q == $past(cnt_q) - CNT_W'(1))
		else $error("release did not shrink queue");
`endif

endmodule

>>> verif/timed_release_delay_queue_tb.sv
`timescale 1ns / 100ps

// self-checking bench for the timed release delay queue: every accepted word is
// run through a cycle-free copy of the queue and its statistics, and every done
// strobe is compared against the oldest predicted result
module timed_release_delay_queue_tb;
	import trdq_pkg::*;

	// quiet cycles (no word taken, no result shown) before the run is declared hung
	localparam int HANG_LIMIT = 2000;
	// idle cycles after the last result, longer than a full-queue tick
	localparam int SETTLE_CYCLES = 2 * QUEUE_DEPTH + 40;

	typedef struct {
		status_t          status;
		logic [TAG_W-1:0] tag;
		logic [XFER_W-1:0] transit;
		logic [ACC_W-1:0] mean;
		logic [ACC_W-1:0] jitter;
	} delay_result_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic                busy;
	logic                opcode = OP_TICK;
	logic [TAG_W-1:0]    seq_tag = '0;
	logic [DLY_W-1:0]    delay_ms = '0;
	logic                done;
	logic [1:0]          status;
	logic [TAG_W-1:0]    released_tag;
	logic [XFER_W-1:0]   transit_ms;
	logic [ACC_W-1:0]    mean_transit_q4;
	logic [ACC_W-1:0]    jitter_q4;

	timed_release_delay_queue uut (.*);

	// shadow of the packet queue, oldest entry at index 0
	logic [TAG_W-1:0]  q_tag     [QUEUE_DEPTH];
	logic [TIME_W-1:0] q_arrival [QUEUE_DEPTH];
	logic [TIME_W-1:0] q_due     [QUEUE_DEPTH];
	int                q_count = 0;
	logic [TIME_W-1:0] q_now = '0;
	logic [ACC_W-1:0]  q_mean = '0;
	logic [ACC_W-1:0]  q_dev = '0;

	delay_result_t expected_results[$];

	int sender_idle_pct = 0;
	int words_sent = 0;
	int mismatches = 0;
	int releases_seen = 0;
	int drops_seen = 0;
	int peak_fill = 0;
	int quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// one word through the shadow queue; returns the result it must produce
	function automatic delay_result_t step_delay_queue(opcode_t op, logic [TAG_W-1:0] tag,
			logic [DLY_W-1:0] dly);
		delay_result_t r;
		int hit;
		logic [31:0] diff, t, tq, d, acc;
		r.status = STAT_NONE;
		r.tag = '0;
		r.transit = '0;
		if (op == OP_ENQ) begin
			if (q_count >= QUEUE_DEPTH) begin
				r.status = STAT_DROP;
			end else begin
				q_tag[q_count] = tag;
				q_arrival[q_count] = q_now;
				q_due[q_count] = q_now + 32'(dly);
				q_count++;
				r.status = STAT_ENQ;
				if (q_count > peak_fill)
					peak_fill = q_count;
			end
		end else begin
			q_now = q_now + 1;
			hit = -1;
			// first entry whose release time is not in the future, modulo 2^32
			for (int i = 0; i < q_count; i++) begin
				diff = q_due[i] - q_now;
				if (hit < 0 && (diff == 0 || diff[31]))
					hit = i;
			end
			if (hit >= 0) begin
				t = q_now - q_arrival[hit];
				r.tag = q_tag[hit];
				for (int i = hit; i < q_count - 1; i++) begin
					q_tag[i] = q_tag[i + 1];
					q_arrival[i] = q_arrival[i + 1];
					q_due[i] = q_due[i + 1];
				end
				q_count--;
				// 32-bit shift first, then clamp to the accumulator range
				tq = t << FRAC_BITS;
				if (tq > 32'(ACC_MAX))
					tq = 32'(ACC_MAX);
				acc = 32'(q_mean) - (32'(q_mean) >> ALPHA_SHIFT) + (tq >> ALPHA_SHIFT);
				q_mean = acc[ACC_W-1:0];
				// deviation is taken against the freshly updated mean
				d = (tq >= 32'(q_mean)) ? tq - 32'(q_mean) : 32'(q_mean) - tq;
				acc = 32'(q_dev) - (32'(q_dev) >> ALPHA_SHIFT) + (d >> ALPHA_SHIFT);
				q_dev = acc[ACC_W-1:0];
				r.transit = (t > XFER_MAX) ? XFER_MAX[XFER_W-1:0] : t[XFER_W-1:0];
				r.status = STAT_REL;
			end
		end
		r.mean = q_mean;
		r.jitter = q_dev;
		return r;
	endfunction

	// present one word, hold it until taken, then maybe go quiet for a while
	task automatic send_word(opcode_t op, logic [TAG_W-1:0] tag, logic [DLY_W-1:0] dly);
		start <= 1'b1;
		opcode <= op;
		seq_tag <= tag;
		delay_ms <= dly;
		do
			@(posedge clk);
		while (busy);
		expected_results.push_back(step_delay_queue(op, tag, dly));
		words_sent++;
		if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	// ticks carry junk in the unused fields on purpose
	task automatic send_tick();
		send_word(OP_TICK, TAG_W'($urandom), DLY_W'($urandom));
	endtask

	task automatic drain_queue();
		while (q_count != 0)
			send_tick();
	endtask

	task automatic note_mismatch(string field, logic [31:0] want, logic [31:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%t mismatch on %s: expected 0x%0h, got 0x%0h", $realtime, field, want,
				got);
	endtask

	// empty queue tick, extreme tags and small delays, a later entry due before
	// an earlier one, a zero delay released on the very next tick
	task automatic test_directed();
		send_tick();
		send_word(OP_ENQ, 16'h0000, 16'd5);
		send_word(OP_ENQ, 16'hFFFF, 16'd0);
		send_word(OP_ENQ, 16'h1234, 16'd2);
		send_tick();
		send_tick();
		send_word(OP_ENQ, 16'hABCD, 16'd1);
		send_tick();
		send_tick();
		send_tick();
		send_tick();
		send_word(OP_ENQ, 16'h8001, 16'd3);
		send_word(OP_ENQ, 16'h7FFE, 16'd3);
		drain_queue();
	endtask

	// fill every slot, push two more that must be dropped, then empty it again
	task automatic test_queue_full();
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_word(OP_ENQ, TAG_W'($urandom), DLY_W'($urandom_range(0, 4)));
		send_word(OP_ENQ, 16'hDEAD, 16'd0);
		send_word(OP_ENQ, 16'hBEEF, 16'hFFFF);
		drain_queue();
	endtask

	// mostly short delays so packets keep flowing, with occasional enqueue bursts
	// that run into the full queue and a few long delays that linger
	task automatic test_random(int idle_pct, int n_words);
		int roll;
		logic [DLY_W-1:0] dly;
		sender_idle_pct = idle_pct;
		repeat (n_words) begin
			roll = $urandom_range(99);
			if (roll < 3) begin
				repeat ($urandom_range(8, 40))
					send_word(OP_ENQ, TAG_W'($urandom), DLY_W'($urandom_range(0, 60)));
			end else if (roll < 50) begin
				dly = ($urandom_range(99) < 3) ? DLY_W'($urandom) :
					DLY_W'($urandom_range(0, 40));
				send_word(OP_ENQ, TAG_W'($urandom), dly);
			end else begin
				send_tick();
			end
		end
		sender_idle_pct = 0;
	endtask

	// result check, sampled on the edge that ends the done cycle
	always @(posedge clk) begin : result_check
		delay_result_t want;
		if (done) begin
			if (expected_results.size() == 0) begin
				note_mismatch("unexpected result status", 32'hFFFF_FFFF, 32'(status));
			end else begin
				want = expected_results.pop_front();
				if (status != want.status)
					note_mismatch("status", 32'(want.status), 32'(status));
				if (released_tag != want.tag)
					note_mismatch("released_tag", 32'(want.tag), 32'(released_tag));
				if (transit_ms != want.transit)
					note_mismatch("transit_ms", 32'(want.transit), 32'(transit_ms));
				if (mean_transit_q4 != want.mean)
					note_mismatch("mean_transit_q4", 32'(want.mean), 32'(mean_transit_q4));
				if (jitter_q4 != want.jitter)
					note_mismatch("jitter_q4", 32'(want.jitter), 32'(jitter_q4));
				if (status == STAT_REL)
					releases_seen++;
				if (status == STAT_DROP)
					drops_seen++;
			end
		end
	end

	// hang detector: any accepted word or shown result counts as progress
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= HANG_LIMIT) begin
			$display("%t no progress for %0d cycles", $realtime, HANG_LIMIT);
			$display("[timed_release_delay_queue] ERROR");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_queue_full();
		test_random(0, 70);
		test_random(83, 70);
		test_random(25, 70);

		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d words: %0d releases, %0d drops, peak fill %0d of %0d",
			words_sent, releases_seen, drops_seen, peak_fill, QUEUE_DEPTH);
		$display("final mean 0x%0h, jitter 0x%0h, %0d mismatches", q_mean, q_dev,
			mismatches);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("[timed_release_delay_queue] OK");
		else
			$display("[timed_release_delay_queue] ERROR");
		$finish;
	end

endmodule
